### rtl/lmc_pkg.sv
// lmc_pkg: widths, register map and store entry type for the local minimum counter
`default_nettype none

package lmc_pkg;

    localparam int MAX_ROWS = 1024;
    localparam int MAX_COLS = 1024;
    localparam int PIX_W    = 16;
    localparam int CNT_W    = 21;
    localparam int CFG_W    = 11;
    localparam int ROW_W    = $clog2(MAX_ROWS);
    localparam int COL_W    = $clog2(MAX_COLS);
    localparam int ADDR_W   = 3;
    localparam int APB_W    = 32;
    localparam int IN_TW    = ((PIX_W + 7) / 8) * 8;
    localparam int OUT_TW   = ((CNT_W + 7) / 8) * 8;

    // register index, taken from paddr[2]
    localparam logic REG_ROW_COUNT    = 1'b0;
    localparam logic REG_COLUMN_COUNT = 1'b1;

    typedef struct packed {
        logic                    flag;
        logic signed [PIX_W-1:0] value;
    } t_entry;

endpackage

`default_nettype wire

### rtl/local_minimum_counter.sv
// local_minimum_counter: counts 3x3 local minima of a raster frame, one pixel per beat
//
//  channel  | dir | signals                     | beat
//  ---------+-----+-----------------------------+-------------------------------
//  s_axis   | in  | tvalid tready tdata[15:0]   | one pixel, raster order
//  m_axis   | out | tvalid tready tdata[23:0]   | minima count, once per frame
//  apb      | in  | psel penable pwrite paddr   | row_count @0, column_count @4
//
// one pixel per cycle while s_axis is not stalled; the previous row lives in a 1024 x 17 bit
// single-port-write memory read one column ahead, with forwarding of recent writes.
// the count is registered and appears in the cycle after the last pixel of a frame is accepted.
// s_axis stalls only on the last pixel of a frame while an earlier count is still held.
// synchronous active-low reset clears position, count and sizes (1 x 1); memory is not cleared.
`default_nettype none

module local_minimum_counter (
    input  wire                        i_clk,
    input  wire                        i_rst_n,
    input  wire                        s_axis_tvalid,
    output logic                       s_axis_tready,
    input  wire [lmc_pkg::IN_TW-1:0]   s_axis_tdata,   // [15:0] pixel
    output logic                       m_axis_tvalid,
    input  wire                        m_axis_tready,
    output logic [lmc_pkg::OUT_TW-1:0] m_axis_tdata,   // [20:0] minima_count, rest zero
    input  wire                        psel,
    input  wire                        penable,
    input  wire                        pwrite,
    input  wire [lmc_pkg::ADDR_W-1:0]  paddr,
    input  wire [lmc_pkg::APB_W-1:0]   pwdata,
    output logic [lmc_pkg::APB_W-1:0]  prdata,
    output logic                       pready
);
    import lmc_pkg::*;

    // configuration
    logic [CFG_W-1:0] r_row_cfg, r_col_cfg;
    logic [CFG_W-1:0] h, w;

    // position and running state
    logic [ROW_W-1:0]        r_row;
    logic [COL_W-1:0]        r_col;
    logic signed [PIX_W-1:0] r_left_val;
    logic                    r_left_flag;
    logic signed [PIX_W-1:0] r_ul_val;
    logic                    r_ul_flag;
    t_entry                  r_up;
    t_entry                  r_first;
    logic [CNT_W-1:0]        r_count;

    // row memory and its write/forward paths
    t_entry           mem [MAX_COLS];
    t_entry           r_rd;
    logic             r_fwd_hit;
    t_entry           r_fwd_data;
    logic             r_pend;
    logic [COL_W-1:0] r_pend_addr;
    t_entry           r_pend_data;

    // output register
    logic             r_out_valid;
    logic [CNT_W-1:0] r_out_count;

    logic                    step, cfg_wr;
    logic                    row_gt, col_gt, last_col, last_row, emit;
    logic signed [PIX_W-1:0] x;
    t_entry                  up, ur, left_entry, x_entry;
    logic                    flag, left_flag_n, up_flag_n, ul_flag_n, ur_flag_n;
    logic [2:0]              inc;
    logic [CNT_W-1:0]        sum;
    logic [COL_W-1:0]        n_col, rd_addr, wr_addr;
    logic                    wr_en;
    t_entry                  wr_data;
    logic                    hit_a, hit_b, hit_c;
    t_entry                  fwd_data;

    // size clamping: zero reads as one, oversize saturates
    always_comb begin
        if (r_row_cfg == '0) begin
            h = CFG_W'(1);
        end else if (r_row_cfg > CFG_W'(MAX_ROWS)) begin
            h = CFG_W'(MAX_ROWS);
        end else begin
            h = r_row_cfg;
        end
        if (r_col_cfg == '0) begin
            w = CFG_W'(1);
        end else if (r_col_cfg > CFG_W'(MAX_COLS)) begin
            w = CFG_W'(MAX_COLS);
        end else begin
            w = r_col_cfg;
        end
    end

    assign row_gt   = (r_row != '0);
    assign col_gt   = (r_col != '0);
    assign last_col = ((CFG_W'(r_col) + CFG_W'(1)) >= w);
    assign last_row = ((CFG_W'(r_row) + CFG_W'(1)) >= h);
    assign emit     = last_col && last_row;

    assign s_axis_tready = !(r_out_valid && !m_axis_tready && emit);
    assign step          = s_axis_tvalid && s_axis_tready;
    assign x             = $signed(s_axis_tdata[PIX_W-1:0]);

    // up neighbour: column zero comes from the mirrored first entry
    assign up = col_gt ? r_up : r_first;
    assign ur = r_fwd_hit ? r_fwd_data : r_rd;

    always_comb begin
        flag = 1'b1;
        if (col_gt && (r_left_val < x)) flag = 1'b0;
        if (row_gt) begin
            if (up.value < x) flag = 1'b0;
            if (col_gt && (r_ul_val < x)) flag = 1'b0;
            if (!last_col && (ur.value < x)) flag = 1'b0;
        end
        left_flag_n = r_left_flag && !(col_gt && (x < r_left_val));
        up_flag_n   = row_gt && up.flag && !(x < up.value);
        ul_flag_n   = r_ul_flag && !(x < r_ul_val);
        ur_flag_n   = ur.flag && !(row_gt && !last_col && (x < ur.value));
    end

    assign inc = {2'b00, row_gt && col_gt && ul_flag_n}
               + {2'b00, last_row && col_gt && left_flag_n}
               + {2'b00, last_col && up_flag_n}
               + {2'b00, emit && flag};
    assign sum = r_count + CNT_W'(inc);

    assign left_entry = '{flag: left_flag_n, value: r_left_val};
    assign x_entry    = '{flag: flag, value: x};

    // next position and read-ahead address (upper-right of the next pixel)
    always_comb begin
        n_col = r_col;
        if (step) begin
            n_col = last_col ? '0 : r_col + COL_W'(1);
        end
        rd_addr = n_col + COL_W'(1);
    end

    // write port: left pixel on a beat, else the deferred last-column entry
    always_comb begin
        wr_en   = 1'b0;
        wr_addr = r_pend_addr;
        wr_data = r_pend_data;
        if (step && col_gt) begin
            wr_en   = 1'b1;
            wr_addr = r_col - COL_W'(1);
            wr_data = left_entry;
        end else if (r_pend) begin
            wr_en = 1'b1;
        end
    end

    // forwarding of writes that the registered read would miss
    always_comb begin
        hit_a    = step && col_gt && (rd_addr == r_col - COL_W'(1));
        hit_b    = step && last_col && (rd_addr == r_col);
        hit_c    = r_pend && (rd_addr == r_pend_addr);
        fwd_data = r_pend_data;
        if (hit_a) begin
            fwd_data = left_entry;
        end else if (hit_b) begin
            fwd_data = x_entry;
        end
    end

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        r_rd <= mem[rd_addr];
    end

    always_ff @(posedge i_clk) begin
        r_fwd_data  <= fwd_data;
        r_pend_addr <= r_col;
        r_pend_data <= x_entry;
        if (step) begin
            r_left_val <= x;
            r_ul_val   <= up.value;
            r_up       <= '{flag: ur_flag_n, value: ur.value};
            if (r_col == COL_W'(1)) begin
                r_first <= left_entry;
            end else if (last_col && !col_gt) begin
                r_first <= x_entry;
            end
        end
        if (step && emit) begin
            r_out_count <= sum;
        end
    end

    assign cfg_wr = psel && penable && pwrite;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_row_cfg   <= CFG_W'(1);
            r_col_cfg   <= CFG_W'(1);
            r_row       <= '0;
            r_col       <= '0;
            r_left_flag <= 1'b0;
            r_ul_flag   <= 1'b0;
            r_count     <= '0;
            r_fwd_hit   <= 1'b0;
            r_pend      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (cfg_wr) begin
                unique case (paddr[2])
                    REG_ROW_COUNT:    r_row_cfg <= pwdata[CFG_W-1:0];
                    REG_COLUMN_COUNT: r_col_cfg <= pwdata[CFG_W-1:0];
                    default:          r_row_cfg <= r_row_cfg;
                endcase
            end
            r_fwd_hit <= hit_a || hit_b || hit_c;
            r_pend    <= step && last_col;
            r_col     <= n_col;
            if (step) begin
                r_left_flag <= flag;
                r_ul_flag   <= up_flag_n;
                if (last_col) begin
                    r_row <= last_row ? '0 : r_row + ROW_W'(1);
                end
                r_count <= emit ? '0 : sum;
            end
            if (step && emit) begin
                r_out_valid <= 1'b1;
            end else if (m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = OUT_TW'(r_out_count);

    always_comb begin
        unique case (paddr[2])
            REG_ROW_COUNT:    prdata = APB_W'(r_row_cfg);
            REG_COLUMN_COUNT: prdata = APB_W'(r_col_cfg);
            default:          prdata = '0;
        endcase
    end

    assign pready = 1'b1;

endmodule

`default_nettype wire

### bench/testbench.sv
// testbench for local_minimum_counter: predicted frame minima counts checked against the m_axis beats
`timescale 1ns / 1ps

import lmc_pkg::*;

class minima_scoreboard;
    bit [CFG_W-1:0]          row_reg = 1;
    bit [CFG_W-1:0]          col_reg = 1;
    bit signed [PIX_W-1:0]   prev_row_val [MAX_COLS];
    bit                      prev_row_flag [MAX_COLS];
    bit signed [PIX_W-1:0]   left_val, above_val, above_left_val;
    bit                      left_flag, above_left_flag;
    int                      row_pos, col_pos;
    bit [CNT_W-1:0]          tally;
    bit [CNT_W-1:0]          expected_counts [$];
    int                      failures;

    static function int clamp_size(int v, int maxv);
        if (v == 0) return 1;
        if (v > maxv) return maxv;
        return v;
    endfunction

    function void write_register(logic idx, logic [APB_W-1:0] data);
        if (idx == REG_ROW_COUNT) row_reg = data[CFG_W-1:0];
        else col_reg = data[CFG_W-1:0];
    endfunction

    function int pending();
        return expected_counts.size();
    endfunction

    // one accepted pixel: settle whatever neighbours it completes
    function void note_pixel(bit signed [PIX_W-1:0] x);
        int h, w, r, c;
        bit flag, last_col, last_row, above_flag;
        bit signed [PIX_W-1:0] above_right;
        h = clamp_size(row_reg, MAX_ROWS);
        w = clamp_size(col_reg, MAX_COLS);
        r = row_pos;
        c = col_pos;
        flag = 1'b1;
        last_col = (c + 1 >= w);
        last_row = (r + 1 >= h);
        above_flag = 1'b0;
        if (c > 0) begin
            if (left_val < x) flag = 1'b0;
            if (x < left_val) left_flag = 1'b0;
        end
        if (r > 0) begin
            above_val = prev_row_val[c];
            above_flag = prev_row_flag[c];
            if (above_val < x) flag = 1'b0;
            if (x < above_val) above_flag = 1'b0;
            if (c > 0) begin
                if (above_left_val < x) flag = 1'b0;
                if (x < above_left_val) above_left_flag = 1'b0;
                // upper-left pixel has now seen its last neighbour
                if (above_left_flag) tally++;
            end
            if (!last_col) begin
                above_right = prev_row_val[c + 1];
                if (above_right < x) flag = 1'b0;
                if (x < above_right) prev_row_flag[c + 1] = 1'b0;
            end
        end
        if (last_row && c > 0 && left_flag) tally++;
        if (c > 0) begin
            prev_row_val[c - 1] = left_val;
            prev_row_flag[c - 1] = left_flag;
        end
        above_left_val = above_val;
        above_left_flag = above_flag;
        left_val = x;
        left_flag = flag;
        if (last_col) begin
            if (r > 0 && above_flag) tally++;
            prev_row_val[c] = x;
            prev_row_flag[c] = flag;
            col_pos = 0;
            if (last_row) begin
                if (flag) tally++;
                expected_counts.push_back(tally);
                tally = '0;
                row_pos = 0;
            end else begin
                row_pos = r + 1;
            end
        end else begin
            col_pos = c + 1;
        end
    endfunction

    function void check_count(bit [CNT_W-1:0] actual);
        bit [CNT_W-1:0] want;
        if (expected_counts.size() == 0) begin
            $error("minima_count: expected none, actual %0d", actual);
            failures++;
        end else begin
            want = expected_counts.pop_front();
            if (want != actual) begin
                $error("minima_count: expected %0d, actual %0d", want, actual);
                failures++;
            end
        end
    endfunction
endclass

module testbench;

    localparam int HOLD_CYCLES = 300;
    localparam int QUIET_LIMIT = 4000;
    // directed frames send 32 pixels, the random frames fill up the rest
    localparam int RANDOM_ITEMS = 1018;

    typedef enum int {PIX_FULL, PIX_NARROW, PIX_EXTREME, PIX_MIXED} t_pixel_mode;

    logic              i_clk = 1'b0;
    logic              i_rst_n = 1'b0;
    logic              s_axis_tvalid = 1'b0;
    logic              s_axis_tready;
    logic [IN_TW-1:0]  s_axis_tdata = '0;   // [15:0] pixel
    logic              m_axis_tvalid;
    logic              m_axis_tready = 1'b0;
    logic [OUT_TW-1:0] m_axis_tdata;        // [20:0] minima_count
    logic              psel = 1'b0;
    logic              penable = 1'b0;
    logic              pwrite = 1'b0;
    logic [ADDR_W-1:0] paddr = '0;
    logic [APB_W-1:0]  pwdata = '0;
    logic [APB_W-1:0]  prdata;
    logic              pready;

    bit calm = 1'b0;
    bit hold_req = 1'b0;
    bit hold_done = 1'b0;

    minima_scoreboard sb = new;

    local_minimum_counter DUT (.*);

    always #5 i_clk = ~i_clk;

    initial begin
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
    end

    // monitors
    always @(posedge i_clk) begin
        if (i_rst_n && psel && penable && pwrite && pready)
            sb.write_register(paddr[2], pwdata);
        if (i_rst_n && s_axis_tvalid && s_axis_tready)
            sb.note_pixel(s_axis_tdata[PIX_W-1:0]);
        if (i_rst_n && m_axis_tvalid && m_axis_tready)
            sb.check_count(m_axis_tdata[CNT_W-1:0]);
    end

    initial begin : watchdog
        int quiet;
        quiet = 0;
        wait (i_rst_n);
        while (quiet < QUIET_LIMIT) begin
            @(posedge i_clk);
            if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
                quiet = 0;
            else
                quiet++;
        end
        $display("Simulation FAILED");
        $finish;
    end

    // count sink
    initial begin : sink
        int stall;
        wait (i_rst_n);
        forever begin
            if (hold_req && !hold_done) begin
                // long hold-off so the count register backs up into s_axis
                m_axis_tready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge i_clk);
                hold_done = 1'b1;
            end
            stall = calm ? 0 : $urandom_range(0, 10);
            if (stall > 0) begin
                m_axis_tready <= 1'b0;
                repeat (stall) @(posedge i_clk);
            end
            m_axis_tready <= 1'b1;
            do @(posedge i_clk); while (!m_axis_tvalid);
        end
    end

    function automatic int frame_len(int rows, int cols);
        return sb.clamp_size(rows, MAX_ROWS) * sb.clamp_size(cols, MAX_COLS);
    endfunction

    function automatic int pick_size();
        int roll;
        roll = $urandom_range(0, 19);
        if (roll == 0) return 0;
        if (roll < 17) return $urandom_range(1, 6);
        return $urandom_range(7, 24);
    endfunction

    function automatic shortint draw_pixel(t_pixel_mode mode);
        t_pixel_mode m;
        m = (mode == PIX_MIXED) ? t_pixel_mode'($urandom_range(0, 2)) : mode;
        case (m)
            PIX_NARROW: begin
                return shortint'(int'($urandom_range(0, 4)) - 2);
            end
            PIX_EXTREME: begin
                case ($urandom_range(0, 3))
                    0: return shortint'(-32768);
                    1: return shortint'(32767);
                    2: return shortint'(0);
                    default: return shortint'(-1);
                endcase
            end
            default: begin
                return shortint'($urandom);
            end
        endcase
    endfunction

    task automatic write_reg(input logic idx, input logic [APB_W-1:0] value);
        @(posedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= value;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    task automatic send_pixel(input shortint px);
        int gap;
        gap = calm ? 0 : $urandom_range(0, 10);
        if (gap > 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= px;
        do @(posedge i_clk); while (!s_axis_tready);
    endtask

    // sizes change only at a frame boundary with every count delivered
    task automatic open_phase(input int rows, input int cols);
        @(posedge i_clk);
        while (sb.pending() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
        write_reg(REG_ROW_COUNT, rows);
        write_reg(REG_COLUMN_COUNT, cols);
    endtask

    task automatic close_phase();
        s_axis_tvalid <= 1'b0;
    endtask

    task automatic run_phase(input int rows, input int cols, input int frames,
                             input t_pixel_mode mode);
        open_phase(rows, cols);
        repeat (frames * frame_len(rows, cols)) send_pixel(draw_pixel(mode));
        close_phase();
    endtask

    initial begin : stimulus
        shortint single_px [2];
        shortint tile_3x3 [9];
        shortint strip_row [4];
        shortint strip_col [4];
        int random_items;
        int rows, cols, frames, len;
        single_px = '{-32768, 32767};
        tile_3x3 = '{0, 0, -1, 5, -32768, 32767, 32767, -32768, 0};
        strip_row = '{3, 1, 1, 2};
        strip_col = '{-5, 7, -5, -5};
        random_items = 0;
        wait (i_rst_n);
        @(posedge i_clk);

        // single-pixel frames at the value extremes
        open_phase(1, 1);
        foreach (single_px[i]) send_pixel(single_px[i]);
        close_phase();
        // zero sizes behave as one
        open_phase(0, 0);
        send_pixel(shortint'(0));
        close_phase();
        // plateaus and extremes inside a 3x3 frame
        open_phase(3, 3);
        foreach (tile_3x3[i]) send_pixel(tile_3x3[i]);
        close_phase();
        open_phase(1, 4);
        foreach (strip_row[i]) send_pixel(strip_row[i]);
        close_phase();
        open_phase(4, 1);
        foreach (strip_col[i]) send_pixel(strip_col[i]);
        close_phase();

        // back-to-back tiny frames against a stalled sink
        calm = 1'b1;
        hold_req = 1'b1;
        run_phase(1, 1, 12, PIX_FULL);
        calm = 1'b0;

        // random frames, kept within the pixel budget
        while (random_items < RANDOM_ITEMS) begin
            do begin
                rows = pick_size();
                cols = pick_size();
                len = frame_len(rows, cols);
            end while (len > RANDOM_ITEMS - random_items);
            frames = $urandom_range(1, 3);
            while (frames > 1 && random_items + frames * len > RANDOM_ITEMS)
                frames--;
            calm = ($urandom_range(0, 4) == 0);
            run_phase(rows, cols, frames, t_pixel_mode'($urandom_range(0, 3)));
            random_items += frames * len;
        end
        calm = 1'b0;

        @(posedge i_clk);
        while (sb.pending() != 0) @(posedge i_clk);
        repeat (10) @(posedge i_clk);
        if (sb.failures == 0 && sb.pending() == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule

### sim.f
rtl/lmc_pkg.sv
rtl/local_minimum_counter.sv
bench/testbench.sv
